@@ sv/esm_pkg.sv @@
package esm_pkg;

  // Width of one pattern character and of the pattern register.
  localparam int unsigned CHAR_W    = 8;
  localparam int unsigned PATTERN_W = 64;
  localparam int unsigned LEN_REG_W = 4;
  localparam int unsigned WAIT_W    = 16;
  localparam int unsigned ELAPSED_W = 17;

  // Request codes carried by in_req_type.
  localparam logic [1:0] REQ_BYTE  = 2'd0;
  localparam logic [1:0] REQ_TICK  = 2'd1;
  localparam logic [1:0] REQ_ABORT = 2'd2;
  localparam logic [1:0] REQ_START = 2'd3;

  // Search status codes carried by out_search_status.
  localparam logic [1:0] STATUS_WAITING = 2'd0;
  localparam logic [1:0] STATUS_MATCHED = 2'd1;
  localparam logic [1:0] STATUS_TIMEOUT = 2'd2;
  localparam logic [1:0] STATUS_ABORTED = 2'd3;

  // Configuration register indexes.
  localparam logic [1:0] CFG_PATTERN = 2'd0;
  localparam logic [1:0] CFG_LEN     = 2'd1;
  localparam logic [1:0] CFG_WAIT    = 2'd2;

  // Reset values of the configuration registers.
  localparam logic [PATTERN_W-1:0] PATTERN_RESET = '0;
  localparam logic [LEN_REG_W-1:0] LEN_RESET     = 4'd1;
  localparam logic [WAIT_W-1:0]    WAIT_RESET    = 16'd30;

  // Per-transaction control handed from the top level to the state units.
  typedef struct packed {
    logic clear;
    logic shift;
    logic tick;
  } esm_ctl_t;

  // Folds ASCII upper-case letters to lower case; other codes pass unchanged.
  function automatic logic [CHAR_W-1:0] fold_case(input logic [CHAR_W-1:0] c);
    logic [CHAR_W-1:0] r;
    r = c;
    if (c >= 8'h41 && c <= 8'h5A) begin
      r = c + 8'h20;
    end
    return r;
  endfunction

endpackage

@@ sv/expect_string_matcher.sv @@
// Expect-string matcher: watches received modem bytes for a configured string,
// compared without regard to ASCII letter case, and counts one-second ticks
// against a wait limit. Each input transaction (byte, tick, abort or start)
// yields exactly one result transaction carrying the search status after it.
// The block accepts one transaction per cycle unless the result side holds
// results back. An accepted transaction is registered in the input register
// and moves into the result register once that register is free; its result
// is then held there until the result side takes it. The rate is set only by
// how fast the result side takes results. Once a search has ended, only a
// start transaction clears the window, the timer and the outcome.
// Configuration is written through the cfg port, which is always ready, and
// should be written while the block is idle.
module expect_string_matcher #(
  parameter int unsigned MAX_PATTERN = 8
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // Input channel
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [1:0]                        in_req_type,
  input  logic [esm_pkg::CHAR_W-1:0]        in_rx_byte,
  // Result channel
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [1:0]                        out_search_status,
  // Configuration write channel
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [1:0]                        cfg_index,
  input  logic [esm_pkg::PATTERN_W-1:0]     cfg_data
);

  logic [esm_pkg::PATTERN_W-1:0] pattern_r;
  logic [esm_pkg::LEN_REG_W-1:0] pattern_len_r;
  logic [esm_pkg::WAIT_W-1:0]    wait_seconds_r;

  logic                          s1_valid_r;
  logic [1:0]                    s1_req_r;
  logic [esm_pkg::CHAR_W-1:0]    s1_byte_r;
  logic                          s1_go;

  logic [1:0]                    outcome_r;
  logic [1:0]                    outcome_nxt;
  logic                          out_valid_r;
  logic [1:0]                    out_status_r;

  esm_pkg::esm_ctl_t             ctl;
  logic                          match;
  logic                          timeout;

  // Configuration registers.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pattern_r      <= esm_pkg::PATTERN_RESET;
      pattern_len_r  <= esm_pkg::LEN_RESET;
      wait_seconds_r <= esm_pkg::WAIT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        esm_pkg::CFG_PATTERN: pattern_r      <= cfg_data;
        esm_pkg::CFG_LEN:     pattern_len_r  <= cfg_data[esm_pkg::LEN_REG_W-1:0];
        esm_pkg::CFG_WAIT:    wait_seconds_r <= cfg_data[esm_pkg::WAIT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Handshake: the input register moves on whenever the result register is free.
  assign s1_go    = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || s1_go;

  // Input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_req_r  <= in_req_type;
      s1_byte_r <= in_rx_byte;
    end
  end

  // Control for the window and timer; once the search has ended, only a start moves them.
  always_comb begin
    ctl.clear = s1_go && (s1_req_r == esm_pkg::REQ_START);
    ctl.shift = s1_go && (outcome_r == esm_pkg::STATUS_WAITING) &&
                (s1_req_r == esm_pkg::REQ_BYTE);
    ctl.tick  = s1_go && (outcome_r == esm_pkg::STATUS_WAITING) &&
                (s1_req_r == esm_pkg::REQ_TICK);
  end

  esm_window #(
    .MAX_PATTERN (MAX_PATTERN)
  ) u_window (
    .clk         (clk),
    .rst_n       (rst_n),
    .ctl         (ctl),
    .rx_byte     (s1_byte_r),
    .pattern     (pattern_r),
    .pattern_len (pattern_len_r),
    .match       (match)
  );

  esm_timer u_timer (
    .clk          (clk),
    .rst_n        (rst_n),
    .ctl          (ctl),
    .wait_seconds (wait_seconds_r),
    .timeout      (timeout)
  );

  // Next outcome for the transaction in the input register.
  always_comb begin
    outcome_nxt = outcome_r;
    if (s1_req_r == esm_pkg::REQ_START) begin
      outcome_nxt = esm_pkg::STATUS_WAITING;
    end else if (outcome_r == esm_pkg::STATUS_WAITING) begin
      unique case (s1_req_r)
        esm_pkg::REQ_BYTE:  outcome_nxt = match ? esm_pkg::STATUS_MATCHED
                                                : esm_pkg::STATUS_WAITING;
        esm_pkg::REQ_TICK:  outcome_nxt = timeout ? esm_pkg::STATUS_TIMEOUT
                                                  : esm_pkg::STATUS_WAITING;
        esm_pkg::REQ_ABORT: outcome_nxt = esm_pkg::STATUS_ABORTED;
        default:            outcome_nxt = esm_pkg::STATUS_WAITING;
      endcase
    end
  end

  // Outcome state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      outcome_r <= esm_pkg::STATUS_WAITING;
    end else if (s1_go) begin
      outcome_r <= outcome_nxt;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_go) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go) begin
      out_status_r <= outcome_nxt;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_search_status = out_status_r;

  // An ended search stays ended until a start transaction comes through.
  a_outcome_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    s1_go && (outcome_r != esm_pkg::STATUS_WAITING) &&
    (s1_req_r != esm_pkg::REQ_START) |=> outcome_r == $past(outcome_r))
    else $error("outcome changed after the search had ended");

  // A start transaction always reports waiting.
  a_start_clears: assert property (@(posedge clk) disable iff (!rst_n)
    s1_go && (s1_req_r == esm_pkg::REQ_START) |=>
    outcome_r == esm_pkg::STATUS_WAITING && out_search_status == esm_pkg::STATUS_WAITING)
    else $error("start did not clear the outcome");

  // The presented result always equals the outcome state it was loaded with.
  a_result_tracks_state: assert property (@(posedge clk) disable iff (!rst_n)
    s1_go |=> out_valid && out_search_status == outcome_r)
    else $error("result register disagrees with outcome state");

  // The input side stalls only when both pipeline registers are full and blocked.
  a_stall_reason: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> s1_valid_r && out_valid_r && !out_ready)
    else $error("input stalled without a full pipeline");

endmodule

@@ sv/esm_window.sv @@
module esm_window #(
  parameter int unsigned MAX_PATTERN = 8
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  esm_pkg::esm_ctl_t                  ctl,
  input  logic [esm_pkg::CHAR_W-1:0]         rx_byte,
  input  logic [esm_pkg::PATTERN_W-1:0]      pattern,
  input  logic [esm_pkg::LEN_REG_W-1:0]      pattern_len,
  output logic                               match
);

  localparam int unsigned IDX_W = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
  localparam int unsigned LEN_W = $clog2(MAX_PATTERN + 1);

  // Window of the most recent bytes, entry 0 is the oldest.
  logic [esm_pkg::CHAR_W-1:0] recent_r   [MAX_PATTERN];
  logic [esm_pkg::CHAR_W-1:0] recent_nxt [MAX_PATTERN];
  logic [LEN_W-1:0]           n_used;

  // Clamp the configured length into 1..MAX_PATTERN.
  always_comb begin
    if (pattern_len == '0) begin
      n_used = LEN_W'(1);
    end else if ({{(32-esm_pkg::LEN_REG_W){1'b0}}, pattern_len} > 32'(MAX_PATTERN)) begin
      n_used = LEN_W'(MAX_PATTERN);
    end else begin
      n_used = LEN_W'(pattern_len);
    end
  end

  // Window contents after this byte has been shifted in.
  always_comb begin
    for (int i = 0; i < MAX_PATTERN - 1; i++) begin
      recent_nxt[i] = recent_r[i+1];
    end
    recent_nxt[MAX_PATTERN-1] = rx_byte;
  end

  // Case-folded compare of the newest n_used bytes against the pattern.
  always_comb begin
    logic [IDX_W:0] pos;
    match = 1'b1;
    for (int i = 0; i < MAX_PATTERN; i++) begin
      pos = (IDX_W+1)'(MAX_PATTERN) - (IDX_W+1)'(n_used) + (IDX_W+1)'(i);
      if ((IDX_W+1)'(i) < (IDX_W+1)'(n_used)) begin
        if (esm_pkg::fold_case(recent_nxt[pos[IDX_W-1:0]]) !=
            esm_pkg::fold_case(pattern[esm_pkg::CHAR_W*i +: esm_pkg::CHAR_W])) begin
          match = 1'b0;
        end
      end
    end
  end

  // Window register: cleared on reset and on start, shifted on a byte.
  always_ff @(posedge clk) begin
    if (!rst_n || ctl.clear) begin
      for (int i = 0; i < MAX_PATTERN; i++) begin
        recent_r[i] <= '0;
      end
    end else if (ctl.shift) begin
      for (int i = 0; i < MAX_PATTERN; i++) begin
        recent_r[i] <= recent_nxt[i];
      end
    end
  end

endmodule

@@ sv/esm_timer.sv @@
module esm_timer (
  input  logic                          clk,
  input  logic                          rst_n,
  input  esm_pkg::esm_ctl_t             ctl,
  input  logic [esm_pkg::WAIT_W-1:0]    wait_seconds,
  output logic                          timeout
);

  logic [esm_pkg::ELAPSED_W-1:0] elapsed_r;
  logic [esm_pkg::ELAPSED_W-1:0] elapsed_nxt;

  // Saturating increment and compare against the wait limit.
  always_comb begin
    if (&elapsed_r) begin
      elapsed_nxt = elapsed_r;
    end else begin
      elapsed_nxt = elapsed_r + esm_pkg::ELAPSED_W'(1);
    end
    timeout = elapsed_nxt >
              {{(esm_pkg::ELAPSED_W-esm_pkg::WAIT_W){1'b0}}, wait_seconds};
  end

  // Elapsed seconds since the last start.
  always_ff @(posedge clk) begin
    if (!rst_n || ctl.clear) begin
      elapsed_r <= '0;
    end else if (ctl.tick) begin
      elapsed_r <= elapsed_nxt;
    end
  end

endmodule

@@ bench/tb_expect_string_matcher.sv @@
module tb_expect_string_matcher;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 400000;
  localparam int LIVE_TARGET = 800;
  localparam int PHASE_ITEMS = 100;
  localparam int ROW_COUNT   = 32;

  // One row of the directed script: either a register write or an input transaction.
  typedef struct packed {
    bit          is_cfg;
    logic [1:0]  idx;
    logic [63:0] data;
    logic [1:0]  req;
    logic [7:0]  rx;
    bit          typed;
    logic [1:0]  status;
  } script_row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [1:0]  in_req_type = esm_pkg::REQ_BYTE;
  logic [7:0]  in_rx_byte = 8'h00;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [1:0]  out_search_status;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = esm_pkg::CFG_PATTERN;
  logic [63:0] cfg_data = '0;

  // Shadow copy of the configuration registers.
  logic [63:0] pattern_shadow = esm_pkg::PATTERN_RESET;
  logic [3:0]  len_shadow = esm_pkg::LEN_RESET;
  logic [15:0] wait_shadow = esm_pkg::WAIT_RESET;

  // Predicted search state.
  logic [7:0]  window_q [8];
  logic [16:0] seconds_q = '0;
  logic [1:0]  outcome_q = esm_pkg::STATUS_WAITING;

  logic [1:0]  status_fifo [$];
  logic [1:0]  want_status;
  int          errors = 0;
  int          cycles = 0;
  int          sent_items = 0;
  int          live_items = 0;
  int          settings = 0;
  int          n_match = 0;
  int          n_timeout = 0;
  int          n_abort = 0;
  int          stall_left = 0;
  int          calm_left = 0;
  int          stall_roll;
  bit          sender_calm = 1'b0;

  script_row_t directed_rows [ROW_COUNT] = '{
    // Reset configuration: a single zero pattern byte.
    '{1'b0, esm_pkg::CFG_PATTERN, 64'h0,
      esm_pkg::REQ_BYTE,  8'h41, 1'b1, esm_pkg::STATUS_WAITING},
    '{1'b0, esm_pkg::CFG_PATTERN, 64'h0,
      esm_pkg::REQ_ABORT, 8'h00, 1'b1, esm_pkg::STATUS_ABORTED},
    '{1'b0, esm_pkg::CFG_PATTERN, 64'h0,
      esm_pkg::REQ_TICK,  8'h00, 1'b1, esm_pkg::STATUS_ABORTED},
    '{1'b0, esm_pkg::CFG_PATTERN, 64'h0,
      esm_pkg::REQ_BYTE,  8'h00, 1'b1, esm_pkg::STATUS_ABORTED},
    '{1'b0, esm_pkg::CFG_PATTERN, 64'h0,
      esm_pkg::REQ_START, 8'hFF, 1'b1, esm_pkg::STATUS_WAITING},
    '{1'b0, esm_pkg::CFG_PATTERN, 64'h0,
      esm_pkg::REQ_BYTE,  8'h00, 1'b1, esm_pkg::STATUS_MATCHED},
    // Zero wait: the first tick times out, bytes alone never do.
    '{1'b1, esm_pkg::CFG_WAIT,    64'h0,
      esm_pkg::REQ_BYTE,  8'h00, 1'b0, esm_pkg::STATUS_WAITING},
    '{1'b0, esm_pkg::CFG_PATTERN, 64'h0,
      esm_pkg::REQ_START, 8'h00, 1'b1, esm_pkg::STATUS_WAITING},
    '{1'b0, esm_pkg::CFG_PATTERN, 64'h0,
      esm_pkg::REQ_TICK,  8'h00, 1'b1, esm_pkg::STATUS_TIMEOUT},
    '{1'b0, esm_pkg::CFG_PATTERN, 64'h0,
      esm_pkg::REQ_BYTE,  8'h00, 1'b1, esm_pkg::STATUS_TIMEOUT},
    // Two-character pattern matched in the other letter case.
    '{1'b1, esm_pkg::CFG_PATTERN, 64'h4B4F,
      esm_pkg::REQ_BYTE,  8'h00, 1'b0, esm_pkg::STATUS_WAITING},
    '{1'b1, esm_pkg::CFG_LEN,     64'h2,
      esm_pkg::REQ_BYTE,  8'h00, 1'b0, esm_pkg::STATUS_WAITING},
    '{1'b0, esm_pkg::CFG_PATTERN, 64'h0,
      esm_pkg::REQ_START, 8'h00, 1'b1, esm_pkg::STATUS_WAITING},
    '{1'b0, esm_pkg::CFG_PATTERN, 64'h0,
      esm_pkg::REQ_BYTE,  8'h6F, 1'b1, esm_pkg::STATUS_WAITING},
    '{1'b0, esm_pkg::CFG_PATTERN, 64'h0,
      esm_pkg::REQ_BYTE,  8'h6B, 1'b1, esm_pkg::STATUS_MATCHED},
    // A length of zero acts as one; all-ones pattern.
    '{1'b1, esm_pkg::CFG_LEN,     64'h0,
      esm_pkg::REQ_BYTE,  8'h00, 1'b0, esm_pkg::STATUS_WAITING},
    '{1'b1, esm_pkg::CFG_PATTERN, 64'hFFFF_FFFF_FFFF_FFFF,
      esm_pkg::REQ_BYTE,  8'h00, 1'b0, esm_pkg::STATUS_WAITING},
    '{1'b0, esm_pkg::CFG_PATTERN, 64'h0,
      esm_pkg::REQ_START, 8'h00, 1'b1, esm_pkg::STATUS_WAITING},
    '{1'b0, esm_pkg::CFG_PATTERN, 64'h0,
      esm_pkg::REQ_BYTE,  8'hFF, 1'b1, esm_pkg::STATUS_MATCHED},
    // Oversized length acts as eight; characters around the letter range.
    '{1'b1, esm_pkg::CFG_LEN,     64'hF,
      esm_pkg::REQ_BYTE,  8'h00, 1'b0, esm_pkg::STATUS_WAITING},
    '{1'b1, esm_pkg::CFG_PATTERN, 64'h617A_7B60_415A_5B40,
      esm_pkg::REQ_BYTE,  8'h00, 1'b0, esm_pkg::STATUS_WAITING},
    '{1'b1, esm_pkg::CFG_WAIT,    64'hFFFF,
      esm_pkg::REQ_BYTE,  8'h00, 1'b0, esm_pkg::STATUS_WAITING},
    '{1'b0, esm_pkg::CFG_PATTERN, 64'h0,
      esm_pkg::REQ_START, 8'h00, 1'b1, esm_pkg::STATUS_WAITING},
    '{1'b0, esm_pkg::CFG_PATTERN, 64'h0,
      esm_pkg::REQ_BYTE,  8'h40, 1'b0, esm_pkg::STATUS_WAITING},
    '{1'b0, esm_pkg::CFG_PATTERN, 64'h0,
      esm_pkg::REQ_BYTE,  8'h5B, 1'b0, esm_pkg::STATUS_WAITING},
    '{1'b0, esm_pkg::CFG_PATTERN, 64'h0,
      esm_pkg::REQ_BYTE,  8'h7A, 1'b0, esm_pkg::STATUS_WAITING},
    '{1'b0, esm_pkg::CFG_PATTERN, 64'h0,
      esm_pkg::REQ_BYTE,  8'h61, 1'b0, esm_pkg::STATUS_WAITING},
    '{1'b0, esm_pkg::CFG_PATTERN, 64'h0,
      esm_pkg::REQ_BYTE,  8'h60, 1'b0, esm_pkg::STATUS_WAITING},
    '{1'b0, esm_pkg::CFG_PATTERN, 64'h0,
      esm_pkg::REQ_BYTE,  8'h7B, 1'b0, esm_pkg::STATUS_WAITING},
    '{1'b0, esm_pkg::CFG_PATTERN, 64'h0,
      esm_pkg::REQ_BYTE,  8'h5A, 1'b0, esm_pkg::STATUS_WAITING},
    '{1'b0, esm_pkg::CFG_PATTERN, 64'h0,
      esm_pkg::REQ_BYTE,  8'h41, 1'b0, esm_pkg::STATUS_WAITING},
    '{1'b0, esm_pkg::CFG_PATTERN, 64'h0,
      esm_pkg::REQ_TICK,  8'h00, 1'b0, esm_pkg::STATUS_WAITING}
  };

  expect_string_matcher dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_req_type       (in_req_type),
    .in_rx_byte        (in_rx_byte),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_search_status (out_search_status),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data)
  );

  always #5 clk = ~clk;

  // Idle lengths: mostly none or short, now and then long.
  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 60) begin
      return 0;
    end else if (roll < 92) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [7:0] lower_ascii(input logic [7:0] c);
    return (c >= 8'h41 && c <= 8'h5A) ? c + 8'h20 : c;
  endfunction

  function automatic int chars_in_use();
    if (len_shadow == 0) begin
      return 1;
    end else if (len_shadow > 8) begin
      return 8;
    end
    return int'(len_shadow);
  endfunction

  // Advances the predicted search by one transaction and returns the new status.
  function automatic logic [1:0] advance_search(input logic [1:0] req, input logic [7:0] rx);
    int n;
    bit hit;
    if (req == esm_pkg::REQ_START) begin
      for (int k = 0; k < 8; k++) window_q[k] = 8'h00;
      seconds_q = '0;
      outcome_q = esm_pkg::STATUS_WAITING;
    end else if (outcome_q == esm_pkg::STATUS_WAITING) begin
      case (req)
        esm_pkg::REQ_BYTE: begin
          for (int k = 0; k < 7; k++) window_q[k] = window_q[k + 1];
          window_q[7] = rx;
          n = chars_in_use();
          hit = 1'b1;
          for (int k = 0; k < n; k++) begin
            if (lower_ascii(window_q[8 - n + k]) != lower_ascii(pattern_shadow[8 * k +: 8])) begin
              hit = 1'b0;
            end
          end
          if (hit) begin
            outcome_q = esm_pkg::STATUS_MATCHED;
          end
        end
        esm_pkg::REQ_TICK: begin
          if (seconds_q != 17'h1FFFF) begin
            seconds_q = seconds_q + 17'd1;
          end
          if (seconds_q > {1'b0, wait_shadow}) begin
            outcome_q = esm_pkg::STATUS_TIMEOUT;
          end
        end
        default: begin
          outcome_q = esm_pkg::STATUS_ABORTED;
        end
      endcase
    end
    return outcome_q;
  endfunction

  // Sends one input transaction and records its expected status. Valid stays
  // high after acceptance so that a following transaction can go back to back.
  task automatic send_item(input logic [1:0] req, input logic [7:0] rx,
                           input bit typed, input logic [1:0] typed_status);
    int gap;
    logic [1:0] predicted;
    if (cfg_valid) begin
      cfg_valid <= 1'b0;
    end
    gap = sender_calm ? 0 : pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid    <= 1'b1;
    in_req_type <= req;
    in_rx_byte  <= rx;
    do @(posedge clk); while (!in_ready);
    if (req == esm_pkg::REQ_START || outcome_q == esm_pkg::STATUS_WAITING) begin
      live_items++;
    end
    sent_items++;
    predicted = advance_search(req, rx);
    status_fifo.push_back(typed ? typed_status : predicted);
  endtask

  // Lets every outstanding result come back with the sender held off.
  task automatic drain();
    in_valid <= 1'b0;
    while (status_fifo.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [63:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      esm_pkg::CFG_PATTERN: pattern_shadow = val;
      esm_pkg::CFG_LEN:     len_shadow = val[3:0];
      esm_pkg::CFG_WAIT:    wait_shadow = val[15:0];
      default:              ;
    endcase
    settings++;
  endtask

  // Cycle limit.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("%0t: cycle limit reached with %0d results outstanding", $time,
               status_fifo.size());
      $display("expect_string_matcher regression: fail");
      $finish;
    end
  end

  // Result side: compare each result transaction and stall at random.
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (status_fifo.size() == 0) begin
        errors++;
        $display("%0t: result with nothing expected, expected none, got %0d", $time,
                 out_search_status);
      end else begin
        want_status = status_fifo.pop_front();
        if (want_status !== out_search_status) begin
          errors++;
          $display("%0t: search_status mismatch, expected %0d, got %0d", $time,
                   want_status, out_search_status);
        end
      end
      case (out_search_status)
        esm_pkg::STATUS_MATCHED: n_match++;
        esm_pkg::STATUS_TIMEOUT: n_timeout++;
        esm_pkg::STATUS_ABORTED: n_abort++;
        default:                 ;
      endcase
    end
    if (calm_left > 0) begin
      calm_left <= calm_left - 1;
      out_ready <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
      stall_roll = $urandom_range(0, 99);
      if (stall_roll < 3) begin
        calm_left <= $urandom_range(50, 200);
      end else if (stall_roll < 40) begin
        stall_left <= pick_gap();
      end
    end
  end

  // Stimulus.
  initial begin
    int phase_end;
    int kind;
    int n;
    int bad;
    logic [63:0] pat;
    logic [7:0] c;
    logic [7:0] lc;

    for (int k = 0; k < 8; k++) window_q[k] = 8'h00;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // Directed script.
    foreach (directed_rows[r]) begin
      if (directed_rows[r].is_cfg) begin
        drain();
        write_reg(directed_rows[r].idx, directed_rows[r].data);
      end else begin
        send_item(directed_rows[r].req, directed_rows[r].rx, directed_rows[r].typed,
                  directed_rows[r].status);
      end
    end

    // Random phases, each under its own register setting.
    for (int phase = 0; live_items < LIVE_TARGET; phase++) begin
      drain();
      sender_calm = (phase % 4 == 3);
      if (phase % 3 == 2) begin
        pat = {$urandom, $urandom};
      end else begin
        for (int k = 0; k < 8; k++) begin
          if ($urandom_range(0, 3) != 0) begin
            pat[8 * k +: 8] = ($urandom_range(0, 1) ? 8'h41 : 8'h61) + $urandom_range(0, 25);
          end else begin
            pat[8 * k +: 8] = $urandom_range(8'h21, 8'h7E);
          end
        end
      end
      case (phase % 6)
        0:       write_reg(esm_pkg::CFG_LEN, 64'd8);
        1:       write_reg(esm_pkg::CFG_LEN, 64'd1);
        2:       write_reg(esm_pkg::CFG_LEN, 64'd0);
        3:       write_reg(esm_pkg::CFG_LEN, 64'd15);
        default: write_reg(esm_pkg::CFG_LEN, $urandom_range(1, 8));
      endcase
      case (phase % 5)
        0:       write_reg(esm_pkg::CFG_WAIT, 64'd0);
        1:       write_reg(esm_pkg::CFG_WAIT, 64'd1);
        2:       write_reg(esm_pkg::CFG_WAIT, 64'd65535);
        default: write_reg(esm_pkg::CFG_WAIT, $urandom_range(2, 12));
      endcase
      write_reg(esm_pkg::CFG_PATTERN, pat);
      n = chars_in_use();

      phase_end = live_items + PHASE_ITEMS;
      while (live_items < phase_end && live_items < LIVE_TARGET) begin
        send_item(esm_pkg::REQ_START, $urandom, 1'b0, esm_pkg::STATUS_WAITING);
        kind = $urandom_range(0, 99);
        if (kind < 75) begin
          // Pattern after some noise, in mixed case; some runs carry one corrupted byte.
          repeat ($urandom_range(0, 3)) begin
            send_item(esm_pkg::REQ_BYTE, $urandom, 1'b0, esm_pkg::STATUS_WAITING);
          end
          bad = (kind >= 60) ? $urandom_range(0, n - 1) : -1;
          for (int i = 0; i < n; i++) begin
            c = pattern_shadow[8 * i +: 8];
            lc = c | 8'h20;
            if (lc >= 8'h61 && lc <= 8'h7A && $urandom_range(0, 1) == 1) begin
              c = c ^ 8'h20;
            end
            if (i == bad) begin
              c = c ^ (8'h01 << $urandom_range(0, 7));
            end
            if ($urandom_range(0, 9) == 0) begin
              send_item(esm_pkg::REQ_TICK, $urandom, 1'b0, esm_pkg::STATUS_WAITING);
            end
            send_item(esm_pkg::REQ_BYTE, c, 1'b0, esm_pkg::STATUS_WAITING);
          end
        end else if (kind < 87) begin
          // Run out the clock where the limit is small.
          repeat (wait_shadow < 16 ? wait_shadow + 1 : $urandom_range(1, 16)) begin
            send_item(esm_pkg::REQ_TICK, $urandom, 1'b0, esm_pkg::STATUS_WAITING);
          end
        end else if (kind < 93) begin
          repeat ($urandom_range(0, 4)) begin
            send_item(esm_pkg::REQ_BYTE, $urandom, 1'b0, esm_pkg::STATUS_WAITING);
          end
          send_item(esm_pkg::REQ_ABORT, $urandom, 1'b0, esm_pkg::STATUS_WAITING);
        end else begin
          repeat ($urandom_range(1, 12)) begin
            send_item($urandom_range(0, 2), $urandom, 1'b0, esm_pkg::STATUS_WAITING);
          end
        end
        // Occasional traffic after the search may have ended.
        if ($urandom_range(0, 3) == 0) begin
          send_item($urandom_range(0, 2), $urandom, 1'b0, esm_pkg::STATUS_WAITING);
        end
      end
    end

    drain();
    repeat (20) @(posedge clk);

    $display("Covered %0d input transactions (%0d live) over %0d register writes.",
             sent_items, live_items, settings);
    $display("Results seen: %0d matched, %0d timed out, %0d aborted; %0d errors.",
             n_match, n_timeout, n_abort, errors);
    if (errors == 0) begin
      $display("expect_string_matcher regression: pass");
    end else begin
      $display("expect_string_matcher regression: fail");
    end
    $finish;
  end

endmodule
